/* design/bmhq_pkg.sv */
// Package for the binary min-heap queue core: field widths, codes, shared types.
// No dependencies; bmhq_dp, bmhq_ctrl and the top level import it, bmhq_ram does not.
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int ROW_W    = 10;
  localparam int KEY_W    = 31;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ENTRY_W  = 2 * ROW_W + KEY_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_UPDATE = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_EMPTY     = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] col;
    logic [ROW_W-1:0] row;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_START_INS,
    OP_RD_ROOT,
    OP_RD_POS,
    OP_RD_PARENT,
    OP_UP_MOVE,
    OP_WR_ITEM,
    OP_RM_ROOT,
    OP_RM_LAST,
    OP_RD_LEFT,
    OP_LATCH_L,
    OP_PICK_R,
    OP_DN_MOVE,
    OP_FIND_NEXT,
    OP_FIND_HIT,
    OP_UPD_LD,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       pos_ok;
    logic       up_root;
    logic       up_move;
    logic       dn_has_l;
    logic       dn_has_r;
    logic       dn_move;
    logic       find_hit;
    logic       find_last;
  } dp_sts_t;

endpackage

/* design/bmhq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bmhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bmhq_dp.sv */
// Datapath of the heap queue: slot RAM, moving entry, hole index, count, result words.
// Depends on bmhq_pkg and bmhq_ram.
`timescale 1ns / 1ps
module bmhq_dp
  import bmhq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [1:0]       in_cmd_i,
  input  logic [ROW_W-1:0] in_row_i,
  input  logic [ROW_W-1:0] in_col_i,
  input  logic [KEY_W-1:0] in_key_i,
  input  logic [POS_W-1:0] in_pos_i,
  output dp_sts_t          sts_o,
  output logic [ROW_W-1:0] out_row_o,
  output logic [ROW_W-1:0] out_col_o,
  output logic [KEY_W-1:0] out_key_o,
  output logic [POS_W-1:0] found_pos_o,
  output logic [1:0]       status_o,
  output logic [CNT_W-1:0] total_o
);

  logic [1:0]       cmd_q;
  logic [ROW_W-1:0] row_q;
  logic [ROW_W-1:0] col_q;
  logic [KEY_W-1:0] key_q;
  logic [POS_W-1:0] pos_q;
  entry_t           item_q, item_d;
  entry_t           child_q, child_d;
  logic [POS_W-1:0] cidx_q, cidx_d;
  logic [POS_W-1:0] hole_q, hole_d;
  logic [POS_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  entry_t           res_q, res_d;
  logic [POS_W-1:0] fpos_q, fpos_d;
  logic [POS_W-1:0] o_pos_q;
  entry_t           o_res_q;
  logic [1:0]       o_sts_q;
  logic [CNT_W-1:0] o_cnt_q;

  entry_t           rdata;
  logic             we;
  logic [POS_W-1:0] waddr;
  entry_t           wdata;
  logic [POS_W-1:0] raddr;
  logic [POS_W-1:0] parent;
  logic [CNT_W-1:0] lchild;
  logic [CNT_W-1:0] rchild;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] idx_p1;

  assign parent = POS_W'((hole_q - POS_W'(1)) >> 1);
  assign lchild = {hole_q, 1'b1};
  assign rchild = lchild + CNT_W'(1);
  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign idx_p1 = {1'b0, idx_q} + CNT_W'(1);

  bmhq_ram #(
    .Width(ENTRY_W),
    .Depth(CAPACITY)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    we      = 1'b0;
    waddr   = hole_q;
    wdata   = item_q;
    raddr   = '0;
    item_d  = item_q;
    child_d = child_q;
    cidx_d  = cidx_q;
    hole_d  = hole_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    fpos_d  = fpos_q;
    unique case (cmd_i.op)
      OP_LATCH: begin
        res_d  = '0;
        fpos_d = '0;
      end
      OP_START_INS: begin
        item_d = '{key: key_q, col: col_q, row: row_q};
        hole_d = cnt_q[POS_W-1:0];
      end
      OP_RD_ROOT: begin
        raddr = '0;
        idx_d = '0;
      end
      OP_RD_POS:    raddr = pos_q;
      OP_RD_PARENT: raddr = parent;
      OP_UP_MOVE: begin
        we     = 1'b1;
        wdata  = rdata;
        hole_d = parent;
      end
      OP_WR_ITEM: begin
        we = 1'b1;
        if (cmd_q == CMD_INSERT) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_RM_ROOT: begin
        res_d = rdata;
        cnt_d = cnt_m1;
        raddr = cnt_m1[POS_W-1:0];
      end
      OP_RM_LAST: begin
        item_d = rdata;
        hole_d = '0;
      end
      OP_RD_LEFT: raddr = lchild[POS_W-1:0];
      OP_LATCH_L: begin
        child_d = rdata;
        cidx_d  = lchild[POS_W-1:0];
        raddr   = rchild[POS_W-1:0];
      end
      OP_PICK_R: begin
        if (child_q.key > rdata.key) begin
          child_d = rdata;
          cidx_d  = rchild[POS_W-1:0];
        end
      end
      OP_DN_MOVE: begin
        we     = 1'b1;
        wdata  = child_q;
        hole_d = cidx_q;
      end
      OP_FIND_NEXT: begin
        idx_d = idx_p1[POS_W-1:0];
        raddr = idx_p1[POS_W-1:0];
      end
      OP_FIND_HIT: fpos_d = idx_q;
      OP_UPD_LD: begin
        item_d = '{key: key_q, col: rdata.col, row: rdata.row};
        hole_d = pos_q;
      end
      OP_NONE, OP_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      cmd_q <= in_cmd_i;
      row_q <= in_row_i;
      col_q <= in_col_i;
      key_q <= in_key_i;
      pos_q <= in_pos_i;
    end
    if (cmd_i.op == OP_FINISH) begin
      o_res_q <= res_q;
      o_pos_q <= fpos_q;
      o_sts_q <= cmd_i.status;
      o_cnt_q <= cnt_q;
    end
    item_q  <= item_d;
    child_q <= child_d;
    cidx_q  <= cidx_d;
    hole_q  <= hole_d;
    idx_q   <= idx_d;
    res_q   <= res_d;
    fpos_q  <= fpos_d;
  end

  assign sts_o.cmd       = cmd_q;
  assign sts_o.full      = cnt_q >= CNT_W'(CAPACITY - 1);
  assign sts_o.empty     = cnt_q == '0;
  assign sts_o.pos_ok    = {1'b0, pos_q} < cnt_q;
  assign sts_o.up_root   = hole_q == '0;
  assign sts_o.up_move   = rdata.key > item_q.key;
  assign sts_o.dn_has_l  = lchild < cnt_q;
  assign sts_o.dn_has_r  = rchild < cnt_q;
  assign sts_o.dn_move   = item_q.key > child_q.key;
  assign sts_o.find_hit  = (rdata.row == row_q) && (rdata.col == col_q);
  assign sts_o.find_last = idx_p1 >= cnt_q;

  assign out_row_o   = o_res_q.row;
  assign out_col_o   = o_res_q.col;
  assign out_key_o   = o_res_q.key;
  assign found_pos_o = o_pos_q;
  assign status_o    = o_sts_q;
  assign total_o     = o_cnt_q;

endmodule

/* design/bmhq_ctrl.sv */
// Controller of the heap queue: sequences insert, remove, find and update on the datapath.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_RD,
    S_UP_CMP,
    S_RM_ROOT,
    S_RM_LAST,
    S_DN_RD,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_FIND_CMP,
    S_UPD_LD,
    S_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] sts_q, sts_d;
  logic       valid_q, valid_d;
  dp_op_e     op;

  always_comb begin
    state_d = state_q;
    sts_d   = sts_q;
    valid_d = valid_q && !out_ready_i;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LATCH;
          sts_d   = STS_OK;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.cmd)
          CMD_INSERT: begin
            if (sts_i.full) begin
              sts_d   = STS_FULL;
              state_d = S_FINISH;
            end else begin
              op      = OP_START_INS;
              state_d = S_UP_RD;
            end
          end
          CMD_REMOVE: begin
            if (sts_i.empty) begin
              sts_d   = STS_EMPTY;
              state_d = S_FINISH;
            end else begin
              op      = OP_RD_ROOT;
              state_d = S_RM_ROOT;
            end
          end
          CMD_FIND: begin
            if (sts_i.empty) begin
              sts_d   = STS_NOT_FOUND;
              state_d = S_FINISH;
            end else begin
              op      = OP_RD_ROOT;
              state_d = S_FIND_CMP;
            end
          end
          default: begin
            if (!sts_i.pos_ok) begin
              sts_d   = STS_NOT_FOUND;
              state_d = S_FINISH;
            end else begin
              op      = OP_RD_POS;
              state_d = S_UPD_LD;
            end
          end
        endcase
      end
      S_UP_RD: begin
        if (sts_i.up_root) begin
          op      = OP_WR_ITEM;
          state_d = S_FINISH;
        end else begin
          op      = OP_RD_PARENT;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_move) begin
          op      = OP_UP_MOVE;
          state_d = S_UP_RD;
        end else begin
          op      = OP_WR_ITEM;
          state_d = S_FINISH;
        end
      end
      S_RM_ROOT: begin
        op      = OP_RM_ROOT;
        state_d = S_RM_LAST;
      end
      S_RM_LAST: begin
        op      = OP_RM_LAST;
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts_i.dn_has_l) begin
          op      = OP_RD_LEFT;
          state_d = S_DN_L;
        end else begin
          op      = OP_WR_ITEM;
          state_d = S_FINISH;
        end
      end
      S_DN_L: begin
        op      = OP_LATCH_L;
        state_d = sts_i.dn_has_r ? S_DN_R : S_DN_CMP;
      end
      S_DN_R: begin
        op      = OP_PICK_R;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.dn_move) begin
          op      = OP_DN_MOVE;
          state_d = S_DN_RD;
        end else begin
          op      = OP_WR_ITEM;
          state_d = S_FINISH;
        end
      end
      S_FIND_CMP: begin
        if (sts_i.find_hit) begin
          op      = OP_FIND_HIT;
          state_d = S_FINISH;
        end else if (sts_i.find_last) begin
          sts_d   = STS_NOT_FOUND;
          state_d = S_FINISH;
        end else begin
          op = OP_FIND_NEXT;
        end
      end
      S_UPD_LD: begin
        op      = OP_UPD_LD;
        state_d = S_UP_RD;
      end
      S_FINISH: begin
        if (!valid_q || out_ready_i) begin
          op      = OP_FINISH;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sts_q   <= STS_OK;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sts_q   <= sts_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = state_q == S_IDLE;
  assign out_valid_o  = valid_q;
  assign cmd_o.op     = op;
  assign cmd_o.status = sts_q;

endmodule

/* design/binary_min_heap_queue_core.sv */
// Top level of the binary min-heap queue core: stream ports, controller and datapath.
// Depends on bmhq_pkg, bmhq_ctrl, bmhq_dp (and bmhq_ram below it).
//
// Channel   Dir  tuser           tdata (lowest bit up)
// s_axis    in   command[1:0]    row[9:0] col[19:10] key[50:20] position[56:51] zero[63:57]
// m_axis    out  status[1:0]     out_row[9:0] out_col[19:10] out_key[50:20]
//                                found_position[56:51] entry_total[63:57]
//
// One command at a time; the slot RAM has one read and one write port.
// Insert writes the new entry at the end and climbs toward the root one level at a time;
// update loads the entry at the given position and then climbs as insert does; remove
// takes the root, moves the last entry to the root and descends; find scans the slots
// in order from the root; full, empty or bad position go straight to the result word.
// A finished word waits in the output register while the next command is taken;
// the last cycle of that command holds until the waiting word leaves.
// Reset empties the heap at once; slot contents are not cleared.
`timescale 1ns / 1ps
module binary_min_heap_queue_core
  import bmhq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // row, col, key, position
  input  logic [1:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // out_row, out_col, out_key, found_position, entry_total
  output logic [1:0]  m_axis_tuser   // status
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [ROW_W-1:0] out_row;
  logic [ROW_W-1:0] out_col;
  logic [KEY_W-1:0] out_key;
  logic [POS_W-1:0] found_pos;
  logic [1:0]       status;
  logic [CNT_W-1:0] total;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmhq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_cmd_i   (s_axis_tuser),
    .in_row_i   (s_axis_tdata[9:0]),
    .in_col_i   (s_axis_tdata[19:10]),
    .in_key_i   (s_axis_tdata[50:20]),
    .in_pos_i   (s_axis_tdata[56:51]),
    .sts_o      (sts),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .out_key_o  (out_key),
    .found_pos_o(found_pos),
    .status_o   (status),
    .total_o    (total)
  );

  assign m_axis_tdata = {total, found_pos, out_key, out_col, out_row};
  assign m_axis_tuser = status;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:57] <= CNT_W'(CAPACITY - 1))
    else $error("entry total above capacity");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STS_FULL) |->
      m_axis_tdata[63:57] == CNT_W'(CAPACITY - 1))
    else $error("full reported below capacity");

  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == STS_EMPTY) |-> m_axis_tdata[63:57] == '0)
    else $error("empty reported with entries");

endmodule

/* dv/tb_top.sv */
// Testbench for binary_min_heap_queue_core: directed and random heap commands over stream ports.
// Depends on bmhq_pkg and binary_min_heap_queue_core; predicts each result word with a heap model held in the bench.
`timescale 1ns / 1ps
module tb_top;
  import bmhq_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] fpos;
    logic [1:0]       status;
    logic [CNT_W-1:0] total;
  } heap_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  entry_t      heap_slot [CAPACITY];
  int          heap_count;
  heap_reply_t reply_queue [$];
  int          error_count;
  int          cycle_count;
  bit          idle_on = 1'b1;

  binary_min_heap_queue_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // model
  task automatic swap_slots(input int a, input int b);
    entry_t t;
    t = heap_slot[a];
    heap_slot[a] = heap_slot[b];
    heap_slot[b] = t;
  endtask

  task automatic climb(input int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_slot[p].key <= heap_slot[i].key) break;
      swap_slots(i, p);
      i = p;
    end
  endtask

  task automatic heap_apply(input logic [1:0] cmd, input logic [ROW_W-1:0] row,
                            input logic [ROW_W-1:0] col, input logic [KEY_W-1:0] key,
                            input logic [POS_W-1:0] pos);
    heap_reply_t r;
    int i;
    int c;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (heap_count + 1 < CAPACITY) begin
          heap_slot[heap_count] = '{key: key, col: col, row: row};
          climb(heap_count);
          heap_count++;
        end else r.status = STS_FULL;
      end
      CMD_REMOVE: begin
        if (heap_count == 0) r.status = STS_EMPTY;
        else begin
          r.row = heap_slot[0].row;
          r.col = heap_slot[0].col;
          r.key = heap_slot[0].key;
          heap_count--;
          heap_slot[0] = heap_slot[heap_count];
          i = 0;
          while (2 * i + 1 < heap_count) begin
            c = 2 * i + 1;
            if (c + 1 < heap_count && heap_slot[c].key > heap_slot[c + 1].key) c++;
            if (heap_slot[i].key <= heap_slot[c].key) break;
            swap_slots(i, c);
            i = c;
          end
        end
      end
      CMD_FIND: begin
        r.status = STS_NOT_FOUND;
        for (i = 0; i < heap_count; i++) begin
          if (heap_slot[i].row == row && heap_slot[i].col == col) begin
            r.fpos = POS_W'(i);
            r.status = STS_OK;
            break;
          end
        end
      end
      default: begin
        if (int'(pos) < heap_count) begin
          heap_slot[pos].key = key;
          climb(int'(pos));
        end else r.status = STS_NOT_FOUND;
      end
    endcase
    r.total = CNT_W'(heap_count);
    reply_queue.push_back(r);
  endtask

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(negedge clk_i);
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic [ROW_W-1:0] row,
                           input logic [ROW_W-1:0] col, input logic [KEY_W-1:0] key,
                           input logic [POS_W-1:0] pos);
    idle_gap();
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {7'd0, pos, key, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    heap_apply(cmd, row, col, key, pos);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    heap_reply_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_queue.size() == 0) report("unexpected word", m_axis_tdata, 64'd0);
      else begin
        w = reply_queue.pop_front();
        if (m_axis_tdata[9:0] != w.row)
          report("out_row", 64'(m_axis_tdata[9:0]), 64'(w.row));
        if (m_axis_tdata[19:10] != w.col)
          report("out_col", 64'(m_axis_tdata[19:10]), 64'(w.col));
        if (m_axis_tdata[50:20] != w.key)
          report("out_key", 64'(m_axis_tdata[50:20]), 64'(w.key));
        if (m_axis_tdata[56:51] != w.fpos)
          report("found_position", 64'(m_axis_tdata[56:51]), 64'(w.fpos));
        if (m_axis_tdata[63:57] != w.total)
          report("entry_total", 64'(m_axis_tdata[63:57]), 64'(w.total));
        if (m_axis_tuser != w.status) report("status", 64'(m_axis_tuser), 64'(w.status));
      end
    end
  end

  task automatic test_directed();
    send_word(CMD_REMOVE, 10'h3FF, 10'h3FF, 31'h7FFFFFFF, 6'h3F);
    send_word(CMD_FIND, '0, '0, '0, '0);
    send_word(CMD_UPDATE, '0, '0, '0, '0);
    send_word(CMD_INSERT, 10'h3FF, 10'h3FF, 31'h7FFFFFFF, 6'h3F);
    send_word(CMD_INSERT, '0, '0, '0, '0);
    send_word(CMD_INSERT, 10'd5, 10'd6, '0, '0);
    send_word(CMD_INSERT, 10'd7, 10'd8, 31'h7FFFFFFF, '0);
    send_word(CMD_FIND, 10'h3FF, 10'h3FF, '0, '0);
    send_word(CMD_FIND, 10'd1, 10'd1, '0, '0);
    send_word(CMD_UPDATE, '0, '0, 31'h7FFFFFFF, 6'd3);
    send_word(CMD_UPDATE, '0, '0, '0, 6'h3F);
    send_word(CMD_UPDATE, '0, '0, 31'h7FFFFFFF, '0);
    send_word(CMD_UPDATE, '0, '0, '0, 6'd2);
    repeat (6) send_word(CMD_REMOVE, '0, '0, '0, '0);
  endtask

  task automatic test_fill_full();
    repeat (CAPACITY + 2)
      send_word(CMD_INSERT, ROW_W'($urandom), ROW_W'($urandom),
                KEY_W'($urandom_range(0, 20)), '0);
    send_word(CMD_FIND, heap_slot[CAPACITY - 2].row, heap_slot[CAPACITY - 2].col, '0, '0);
    send_word(CMD_UPDATE, '0, '0, '0, POS_W'(CAPACITY - 2));
    send_word(CMD_UPDATE, '0, '0, '0, POS_W'(CAPACITY - 1));
    repeat (CAPACITY + 1) send_word(CMD_REMOVE, '0, '0, '0, '0);
  endtask

  task automatic test_random(input int n);
    int k;
    int r;
    logic [KEY_W-1:0] key;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      key = KEY_W'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) : $urandom);
      if (r < 40)
        send_word(CMD_INSERT,
                  ROW_W'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3)),
                  ROW_W'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3)),
                  key, POS_W'($urandom));
      else if (r < 70)
        send_word(CMD_REMOVE, ROW_W'($urandom), ROW_W'($urandom), KEY_W'($urandom),
                  POS_W'($urandom));
      else if (r < 85) begin
        if (heap_count > 0 && $urandom_range(0, 1) == 1) begin
          int i;
          i = $urandom_range(0, heap_count - 1);
          send_word(CMD_FIND, heap_slot[i].row, heap_slot[i].col, KEY_W'($urandom),
                    POS_W'($urandom));
        end else
          send_word(CMD_FIND, ROW_W'($urandom_range(0, 3)), ROW_W'($urandom_range(0, 3)),
                    '0, POS_W'($urandom));
      end else
        send_word(CMD_UPDATE, ROW_W'($urandom), ROW_W'($urandom), key,
                  POS_W'(heap_count > 0 && $urandom_range(0, 3) != 0 ?
                         $urandom_range(0, heap_count - 1) : $urandom));
    end
  endtask

  initial begin
    heap_count = 0;
    error_count = 0;
    cycle_count = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_full();
    test_random(560);
    idle_on = 1'b0;
    test_random(100);
    while (reply_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* binary_min_heap_queue_core.f */
design/bmhq_pkg.sv
design/bmhq_ram.sv
design/bmhq_dp.sv
design/bmhq_ctrl.sv
design/binary_min_heap_queue_core.sv
dv/tb_top.sv
